[rtl/core/oqsm_pkg.sv]
`timescale 1ns / 1ps
package oqsm_pkg;

  localparam int HEADER_BYTES  = 4;
  localparam int HEADER_POINTS = 16;
  localparam int BYTE_POINTS   = 4;
  localparam int MAX_TONES     = 68;
  localparam int MIN_TONES     = 36;
  localparam int RESET_TONES   = 64;
  localparam int CENTRE_TONES  = 4;
  localparam int MAX_POINTS    = 64;

  // ceil((len + 4) * 4 / p) numerator: (len + 4) * 4 + p - 1 fits in 15 bits
  localparam int DIV_W     = 15;
  localparam int DIV_STEPS = DIV_W;

  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_BYTE,
    SRC_PAD
  } src_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
    src_t src;
    logic last_point;
    logic end_packet;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_packet;
    logic div_done;
    logic wrap;
    logic out_free;
    logic last_byte;
  } dp_status_t;

endpackage

[rtl/core/ofdm_qpsk_subcarrier_mapper.sv]
`timescale 1ns / 1ps
// QPSK subcarrier mapper: each accepted byte becomes four QPSK points, most
// significant bit pair first, one point per cycle on the output channel while
// it is not stalled. The first byte of a packet is preceded by 16 header points
// carrying the 12-bit length twice, and the final byte (last_byte set) is
// followed by zero-bit points that complete the current OFDM symbol (at most
// 64 points per byte). tone_count is clamped to 36..68, made even, and sampled
// on a packet's first byte. Sequence: an ordinary byte is accepted and then
// emits its four points; a first byte runs the bit-serial divider that computes
// symbols_in_packet (15 quotient steps) and emits the 16 header points before
// its own; a last byte then emits its padding points. The output register
// frees the input side so the next request is taken while the final point
// still waits downstream.
module ofdm_qpsk_subcarrier_mapper
  import oqsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  tone_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic [11:0] payload_length,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        i_negative,
  output logic        q_negative,
  output logic [6:0]  tone_position,
  output logic [9:0]  symbol_index,
  output logic        first_symbol,
  output logic [10:0] symbols_in_packet,
  output logic        last_point
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  oqsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  oqsm_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_tones         (tone_count),
    .payload_byte      (payload_byte),
    .payload_length    (payload_length),
    .last_byte         (last_byte),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .i_negative        (i_negative),
    .q_negative        (q_negative),
    .tone_position     (tone_position),
    .symbol_index      (symbol_index),
    .first_symbol      (first_symbol),
    .symbols_in_packet (symbols_in_packet),
    .last_point        (last_point)
  );

endmodule

[rtl/core/oqsm_ctrl.sv]
`timescale 1ns / 1ps
module oqsm_ctrl
  import oqsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_HDR,
    S_DATA,
    S_PAD
  } state_t;

  localparam logic [3:0] HDR_LAST  = 4'(HEADER_POINTS - 1);
  localparam logic [3:0] BYTE_LAST = 4'(BYTE_POINTS - 1);
  localparam logic [5:0] PT_LAST   = 6'(MAX_POINTS - 1);

  state_t     state;
  logic [3:0] cnt;
  logic [5:0] n;
  logic       accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.src = SRC_PAD;
    case (state)
      S_IDLE: cmd.load = accept;
      S_DIV:  cmd.div_step = !sts.div_done;
      S_HDR: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_HDR;
      end
      S_DATA: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_BYTE;
        if (cnt == BYTE_LAST) begin
          if (!sts.last_byte) begin
            cmd.last_point = 1'b1;
          end else if (sts.wrap) begin
            // last byte closed the symbol exactly, nothing to pad
            cmd.last_point = 1'b1;
            cmd.end_packet = 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd.emit = sts.out_free;
        if (sts.wrap || n == PT_LAST) begin
          cmd.last_point = 1'b1;
          cmd.end_packet = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b1;
      cnt      <= '0;
      n        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            in_stall <= 1'b1;
            cnt      <= '0;
            n        <= '0;
            state    <= sts.in_packet ? S_DATA : S_DIV;
          end else begin
            in_stall <= 1'b0;
          end
        end
        S_DIV: begin
          if (sts.div_done) state <= S_HDR;
        end
        S_HDR: begin
          if (sts.out_free) begin
            n <= n + 6'd1;
            if (cnt == HDR_LAST) begin
              cnt   <= '0;
              state <= S_DATA;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        S_DATA: begin
          if (sts.out_free) begin
            n   <= n + 6'd1;
            cnt <= cnt + 4'd1;
            if (cnt == BYTE_LAST) begin
              if (cmd.last_point) begin
                state    <= S_IDLE;
                in_stall <= 1'b0;
              end else if (sts.last_byte) begin
                state <= S_PAD;
              end else begin
                state    <= S_IDLE;
                in_stall <= 1'b0;
              end
            end
          end
        end
        S_PAD: begin
          if (sts.out_free) begin
            n <= n + 6'd1;
            if (cmd.last_point) begin
              state    <= S_IDLE;
              in_stall <= 1'b0;
            end
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/core/oqsm_datapath.sv]
`timescale 1ns / 1ps
module oqsm_datapath
  import oqsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_tones,
  input  logic [7:0]  payload_byte,
  input  logic [11:0] payload_length,
  input  logic        last_byte,
  input  logic        out_stall,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  sts,
  output logic        out_valid,
  output logic        i_negative,
  output logic        q_negative,
  output logic [6:0]  tone_position,
  output logic [9:0]  symbol_index,
  output logic        first_symbol,
  output logic [10:0] symbols_in_packet,
  output logic        last_point
);

  logic [6:0]       tones_reg;
  logic             in_packet;
  logic [6:0]       p_lat;
  logic [5:0]       pis;
  logic [9:0]       sym_cnt;
  logic [31:0]      hdr;
  logic [7:0]       byte_reg;
  logic             last_reg;
  logic [DIV_W-1:0] divq;
  logic [6:0]       rem;
  logic [3:0]       div_cnt;

  logic [6:0]       tones_lim;
  logic [6:0]       p_new;
  logic [DIV_W-1:0] dividend;
  logic [7:0]       shifted;
  logic [7:0]       diff;
  logic             ge;
  logic [6:0]       pos_ext;
  logic [6:0]       tone;
  logic [1:0]       code;
  logic             wrap;

  always_comb begin
    if (tones_reg < 7'(MIN_TONES)) tones_lim = 7'(MIN_TONES);
    else if (tones_reg > 7'(MAX_TONES)) tones_lim = 7'(MAX_TONES);
    else tones_lim = tones_reg;
  end

  assign p_new    = {tones_lim[6:1], 1'b0} - 7'(CENTRE_TONES);
  assign dividend = DIV_W'({payload_length, 2'b00}) + DIV_W'(HEADER_BYTES * 4)
                  + DIV_W'(p_new) - DIV_W'(1);

  // restoring divide, one quotient bit per step
  assign shifted = {rem, divq[DIV_W-1]};
  assign ge      = shifted >= {1'b0, p_lat};
  assign diff    = shifted - {1'b0, p_lat};

  assign pos_ext = {1'b0, pis};
  assign tone    = (pos_ext < (p_lat >> 1)) ? pos_ext : pos_ext + 7'(CENTRE_TONES);
  assign wrap    = (pos_ext == p_lat - 7'd1);

  always_comb begin
    case (cmd.src)
      SRC_HDR:  code = hdr[31:30];
      SRC_BYTE: code = byte_reg[7:6];
      default:  code = 2'b00;
    endcase
  end

  assign sts.in_packet = in_packet;
  assign sts.div_done  = (div_cnt == 4'(DIV_STEPS));
  assign sts.wrap      = wrap;
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.last_byte = last_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      tones_reg <= 7'(RESET_TONES);
      in_packet <= 1'b0;
      p_lat     <= 7'(RESET_TONES - CENTRE_TONES);
      pis       <= '0;
      sym_cnt   <= '0;
      div_cnt   <= 4'(DIV_STEPS);
      divq      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) tones_reg <= cfg_tones;

      if (cmd.load) begin
        byte_reg <= payload_byte;
        last_reg <= last_byte;
        if (!in_packet) begin
          in_packet <= 1'b1;
          p_lat     <= p_new;
          pis       <= '0;
          sym_cnt   <= '0;
          hdr       <= {4'b0000, payload_length, 4'b0000, payload_length};
          divq      <= dividend;
          rem       <= '0;
          div_cnt   <= '0;
        end
      end

      if (cmd.div_step) begin
        rem     <= ge ? diff[6:0] : shifted[6:0];
        divq    <= {divq[DIV_W-2:0], ge};
        div_cnt <= div_cnt + 4'd1;
      end

      if (cmd.emit) begin
        out_valid     <= 1'b1;
        i_negative    <= code[1] ^ code[0];
        q_negative    <= code[1];
        tone_position <= tone;
        symbol_index  <= sym_cnt;
        first_symbol  <= (sym_cnt == 10'd0);
        last_point    <= cmd.last_point;
        if (cmd.src == SRC_HDR) hdr <= {hdr[29:0], 2'b00};
        if (cmd.src == SRC_BYTE) byte_reg <= {byte_reg[5:0], 2'b00};
        if (wrap) begin
          pis     <= '0;
          sym_cnt <= sym_cnt + 10'd1;
        end else begin
          pis <= pis + 6'd1;
        end
        if (cmd.end_packet) begin
          in_packet <= 1'b0;
          pis       <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) symbols_in_packet <= divq[10:0];
  end

endmodule

[rtl/core/oqsm_checker.sv]
`timescale 1ns / 1ps
module oqsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  tone_position,
  input logic [9:0]  symbol_index,
  input logic        first_symbol,
  input logic [10:0] symbols_in_packet,
  input logic        last_point
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_position)
      && $stable(symbol_index) && $stable(last_point))
    else $error("stalled point changed");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while mapping");

  a_first_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_symbol == (symbol_index == 10'd0))
    else $error("first_symbol disagrees with symbol_index");

  a_tone_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tone_position <= 7'd67)
    else $error("tone position out of range");

  a_sym_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbols_in_packet != 11'd0)
    else $error("packet reports zero symbols");

endmodule

bind ofdm_qpsk_subcarrier_mapper oqsm_checker u_oqsm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .tone_position     (tone_position),
  .symbol_index      (symbol_index),
  .first_symbol      (first_symbol),
  .symbols_in_packet (symbols_in_packet),
  .last_point        (last_point)
);
